### hw/rtl/rak_pkg.sv
package rak_pkg;

    localparam int KIND_W    = 3;
    localparam int TIME_W    = 64;
    localparam int RTT_W     = 16;
    localparam int SEC_W     = 16;
    localparam int MISS_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    // interval * 1000 for a 16-bit interval stays below 2^26
    localparam int THR_W     = 26;

    localparam logic [SEC_W-1:0]  DEFAULT_MIN_SEC = SEC_W'(15);
    localparam logic [SEC_W-1:0]  DEFAULT_MAX_SEC = SEC_W'(120);
    localparam logic [RTT_W-1:0]  RTT_HIGH_MS     = RTT_W'(300);
    localparam logic [RTT_W-1:0]  RTT_LOW_MS      = RTT_W'(50);
    localparam logic [MISS_W-1:0] DEAD_MISSES     = MISS_W'(3);
    localparam logic [MISS_W-1:0] MISS_CAP        = MISS_W'(255);
    localparam logic [THR_W-1:0]  MS_PER_SEC      = THR_W'(1000);

    typedef enum logic [KIND_W-1:0] {
        K_QUERY = 3'd0,
        K_RTT   = 3'd1,
        K_SENT  = 3'd2,
        K_REPLY = 3'd3,
        K_CHECK = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_INTERVAL = 8'd0,
        REG_MAX_INTERVAL = 8'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        CH_MIN = 2'd0,
        CH_MID = 2'd1,
        CH_MAX = 2'd2
    } t_choice;

    // the three candidate intervals and their thresholds in ms
    typedef struct packed {
        logic [SEC_W-1:0] min_sec;
        logic [SEC_W-1:0] mid_sec;
        logic [SEC_W-1:0] max_sec;
        logic [THR_W-1:0] min_thr;
        logic [THR_W-1:0] mid_thr;
        logic [THR_W-1:0] max_thr;
    } t_ivl_tbl;

endpackage

### hw/rtl/rak_ifs.sv
interface rak_evt_if;
    logic                          valid;
    logic                          ready;
    logic [rak_pkg::KIND_W-1:0]    kind;
    logic [rak_pkg::TIME_W-1:0]    now_ms;
    logic [rak_pkg::RTT_W-1:0]     rtt_sample;

    modport source (output valid, kind, now_ms, rtt_sample, input ready);
    modport sink   (input valid, kind, now_ms, rtt_sample, output ready);
endinterface

interface rak_res_if;
    logic                          valid;
    logic                          ready;
    logic                          due;
    logic                          dead;
    logic                          check_fired;
    logic [rak_pkg::SEC_W-1:0]     interval_sec;

    modport source (output valid, due, dead, check_fired, interval_sec, input ready);
    modport sink   (input valid, due, dead, check_fired, interval_sec, output ready);
endinterface

interface rak_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rak_pkg::CFG_IDX_W-1:0]   index;
    logic [rak_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/rtt_adaptive_keepalive.sv
// Adaptive keepalive supervisor.
// i_evt carries one event request per item: kind (query, rtt sample, probe
// sent, reply received, liveness check), now_ms and rtt_sample. o_res returns
// exactly one result per request: due, dead, check_fired and interval_sec.
// i_cfg writes min_interval (index 0) and max_interval (index 1); it is
// always ready and should only be used while no request is in flight.
// A request passes through one input register and one result register.
// Throughput: one request per cycle while the receiver takes results; the
// smoothed RTT, miss count and send time are all updated as the result
// register loads, so back-to-back requests see each other's effects.
// The interval table (three candidate intervals and their ms thresholds)
// is recomputed from the write data in the cycle of a config write.
// Reset (synchronous, active low) clears both valids, the RTT average,
// miss count, dead flag and last send time, and sets both intervals to
// their defaults of 15 s and 120 s.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then i_evt.ready drops until the result
// is taken.
module rtt_adaptive_keepalive (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rak_evt_if.sink   i_evt,
    rak_cfg_if.sink   i_cfg,
    rak_res_if.source o_res
);
    import rak_pkg::*;

    t_ivl_tbl tbl;

    // config registers and per-choice interval/threshold table
    rak_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_tbl   (tbl)
    );

    // input register, supervisor state and result register
    rak_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tbl   (tbl),
        .i_evt   (i_evt),
        .o_res   (o_res)
    );
endmodule

### hw/rtl/rak_cfg.sv
module rak_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rak_cfg_if.sink           i_cfg,
    output rak_pkg::t_ivl_tbl o_tbl
);
    import rak_pkg::*;

    logic [SEC_W-1:0] r_min, n_min;
    logic [SEC_W-1:0] r_max, n_max;
    logic [SEC_W-1:0] eff_min, eff_max, mid;
    logic [SEC_W:0]   sum;
    logic             wr;
    t_ivl_tbl         r_tbl, n_tbl;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (wr && i_cfg.index == REG_MIN_INTERVAL) begin
            n_min = i_cfg.data;
        end
        if (wr && i_cfg.index == REG_MAX_INTERVAL) begin
            n_max = i_cfg.data;
        end
    end

    // table follows the new register values, so it is current with them
    always_comb begin
        eff_min = (n_min == '0) ? DEFAULT_MIN_SEC : n_min;
        eff_max = (n_max == '0) ? DEFAULT_MAX_SEC : n_max;
        sum     = {1'b0, eff_min} + {1'b0, eff_max};
        mid     = sum[SEC_W:1];
        n_tbl.min_sec = eff_min;
        n_tbl.mid_sec = mid;
        n_tbl.max_sec = eff_max;
        n_tbl.min_thr = THR_W'(eff_min) * MS_PER_SEC;
        n_tbl.mid_thr = THR_W'(mid) * MS_PER_SEC;
        n_tbl.max_thr = THR_W'(eff_max) * MS_PER_SEC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min         <= '0;
            r_max         <= '0;
            r_tbl.min_sec <= DEFAULT_MIN_SEC;
            r_tbl.mid_sec <= SEC_W'((32'(DEFAULT_MIN_SEC) + 32'(DEFAULT_MAX_SEC)) >> 1);
            r_tbl.max_sec <= DEFAULT_MAX_SEC;
            r_tbl.min_thr <= THR_W'(DEFAULT_MIN_SEC) * MS_PER_SEC;
            r_tbl.mid_thr <= THR_W'((32'(DEFAULT_MIN_SEC) + 32'(DEFAULT_MAX_SEC)) >> 1)
                             * MS_PER_SEC;
            r_tbl.max_thr <= THR_W'(DEFAULT_MAX_SEC) * MS_PER_SEC;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
            r_tbl <= n_tbl;
        end
    end

    assign o_tbl = r_tbl;
endmodule

### hw/rtl/rak_core.sv
module rak_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rak_pkg::t_ivl_tbl i_tbl,
    rak_evt_if.sink           i_evt,
    rak_res_if.source         o_res
);
    import rak_pkg::*;

    // input register
    logic                r_in_vld;
    logic [KIND_W-1:0]   r_kind;
    logic [TIME_W-1:0]   r_now;
    logic [RTT_W-1:0]    r_sample;

    // supervisor state
    logic [RTT_W-1:0]    r_avg, n_avg;
    t_choice             r_choice, n_choice;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [MISS_W-1:0]   r_miss, n_miss;
    logic                r_dead, n_dead;

    // result register
    logic                r_out_vld;
    logic                r_due, n_due;
    logic                r_dead_o;
    logic                r_fired, n_fired;
    logic [SEC_W-1:0]    r_ivl, n_ivl;

    logic                out_free, adv, take;
    logic [RTT_W+1:0]    avg_sum;
    logic [THR_W-1:0]    thr;
    logic [TIME_W-1:0]   diff;

    assign out_free    = !r_out_vld || o_res.ready;
    assign adv         = r_in_vld && out_free;
    assign i_evt.ready = !r_in_vld || out_free;
    assign take        = i_evt.valid && i_evt.ready;

    always_comb begin
        n_avg    = r_avg;
        n_choice = r_choice;
        n_last   = r_last;
        n_miss   = r_miss;
        n_dead   = r_dead;
        n_fired  = 1'b0;
        avg_sum  = {1'b0, r_avg, 1'b0} + {2'b00, r_avg} + {2'b00, r_sample};
        case (r_kind)
            K_RTT: begin
                n_avg = (r_avg == '0) ? r_sample : avg_sum[RTT_W+1:2];
                if (n_avg > RTT_HIGH_MS) begin
                    n_choice = CH_MAX;
                end else if (n_avg < RTT_LOW_MS) begin
                    n_choice = CH_MIN;
                end else begin
                    n_choice = CH_MID;
                end
            end
            K_SENT: begin
                n_last = r_now;
                if (r_miss != MISS_CAP) begin
                    n_miss = r_miss + MISS_W'(1);
                end
            end
            K_REPLY: begin
                n_miss = '0;
                n_dead = 1'b0;
            end
            K_CHECK: begin
                if (r_miss >= DEAD_MISSES) begin
                    n_dead  = 1'b1;
                    n_fired = 1'b1;
                end
            end
            default: begin
            end
        endcase

        case (n_choice)
            CH_MAX: begin
                n_ivl = i_tbl.max_sec;
                thr   = i_tbl.max_thr;
            end
            CH_MID: begin
                n_ivl = i_tbl.mid_sec;
                thr   = i_tbl.mid_thr;
            end
            default: begin
                n_ivl = i_tbl.min_sec;
                thr   = i_tbl.min_thr;
            end
        endcase

        // a send resets the elapsed time to zero, and the threshold is never zero
        diff  = r_now - r_last;
        n_due = !n_dead && (r_kind != K_SENT) && (diff >= TIME_W'(thr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_avg     <= '0;
            r_choice  <= CH_MIN;
            r_last    <= '0;
            r_miss    <= '0;
            r_dead    <= 1'b0;
        end else begin
            if (i_evt.ready) begin
                r_in_vld <= i_evt.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_avg     <= n_avg;
                r_choice  <= n_choice;
                r_last    <= n_last;
                r_miss    <= n_miss;
                r_dead    <= n_dead;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind   <= i_evt.kind;
            r_now    <= i_evt.now_ms;
            r_sample <= i_evt.rtt_sample;
        end
        if (adv) begin
            r_due    <= n_due;
            r_dead_o <= n_dead;
            r_fired  <= n_fired;
            r_ivl    <= n_ivl;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.due          = r_due;
    assign o_res.dead         = r_dead_o;
    assign o_res.check_fired  = r_fired;
    assign o_res.interval_sec = r_ivl;
endmodule

### test/rtt_adaptive_keepalive_test.sv
`timescale 1ns / 100ps

// Testbench for the adaptive keepalive supervisor.
// Every event request is pushed into a software copy of the supervisor the
// moment the block accepts it. The status that copy produces is queued, and
// each status the block returns is compared against the oldest queued entry.
// Directed tasks cover reset defaults, RTT steering across the 50/300 ms
// thresholds, miss counting and the dead flag, miss saturation, interval
// registers at their extremes, and a long receiver stall. The bulk of the
// run is random keepalive traffic in phases with different interval settings.
module rtt_adaptive_keepalive_test;
    import rak_pkg::*;

    // kinds with no event attached; they must behave as a time query
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int SETTLE_TICKS = 6;     // lets the input and result registers drain
    localparam int HOLD_OFF     = 300;   // long receiver stall

    typedef struct packed {
        logic             due;
        logic             dead;
        logic             check_fired;
        logic [SEC_W-1:0] interval_sec;
    } t_keepalive_status;

    // receiver stall patterns
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_CADENCE,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rak_evt_if evt_bus ();
    rak_res_if res_bus ();
    rak_cfg_if cfg_bus ();

    rtt_adaptive_keepalive uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow supervisor: interval registers plus link state
    // ------------------------------------------------------------------
    logic [SEC_W-1:0]  cfg_min_sec;
    logic [SEC_W-1:0]  cfg_max_sec;
    logic [RTT_W-1:0]  rtt_avg;
    t_choice           ivl_choice;
    logic [TIME_W-1:0] last_sent_ms;
    logic [MISS_W-1:0] miss_count;
    logic              link_dead;

    t_keepalive_status status_queue[$];

    // bookkeeping
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int cfg_writes;
    int due_seen;
    int fired_seen;
    int quiet_cycles;
    logic [TIME_W-1:0] wall_ms;

    // sender pacing and receiver control
    bit       pace_sender;
    int       burst_left;
    int       hold_off_left;
    t_rx_mode rx_mode;
    int       rx_mode_left;
    int       rx_tick;

    // Zero in either register falls back to the built-in default; the
    // midpoint is taken on the 17-bit sum so it never wraps.
    function automatic logic [SEC_W-1:0] interval_in_force();
        logic [SEC_W-1:0] lo;
        logic [SEC_W-1:0] hi;
        logic [SEC_W:0]   sum;
        lo  = (cfg_min_sec != 0) ? cfg_min_sec : DEFAULT_MIN_SEC;
        hi  = (cfg_max_sec != 0) ? cfg_max_sec : DEFAULT_MAX_SEC;
        sum = {1'b0, lo} + {1'b0, hi};
        case (ivl_choice)
            CH_MAX:  return hi;
            CH_MID:  return sum[SEC_W:1];
            default: return lo;
        endcase
    endfunction

    // Applies one event to the shadow state and returns the status the
    // block must report for it (due is judged after the update).
    function automatic t_keepalive_status apply_event(
        input logic [KIND_W-1:0] kind,
        input logic [TIME_W-1:0] now,
        input logic [RTT_W-1:0]  sample
    );
        t_keepalive_status st;
        logic [RTT_W+1:0]  blend;
        logic [THR_W-1:0]  thr;
        logic [TIME_W-1:0] elapsed;
        st = '0;
        case (kind)
            K_RTT: begin
                blend   = (RTT_W+2)'(3 * rtt_avg + sample);
                rtt_avg = (rtt_avg != 0) ? blend[RTT_W+1:2] : sample;
                if (rtt_avg > RTT_HIGH_MS)
                    ivl_choice = CH_MAX;
                else if (rtt_avg < RTT_LOW_MS)
                    ivl_choice = CH_MIN;
                else
                    ivl_choice = CH_MID;
            end
            K_SENT: begin
                last_sent_ms = now;
                if (miss_count != MISS_CAP)
                    miss_count++;
            end
            K_REPLY: begin
                miss_count = '0;
                link_dead  = 1'b0;
            end
            K_CHECK: begin
                if (miss_count >= DEAD_MISSES) begin
                    link_dead      = 1'b1;
                    st.check_fired = 1'b1;
                end
            end
            default: ;
        endcase
        st.interval_sec = interval_in_force();
        thr     = st.interval_sec * MS_PER_SEC;
        elapsed = now - last_sent_ms;              // wraps modulo 2^64
        st.due  = !link_dead && (elapsed >= TIME_W'(thr));
        st.dead = link_dead;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly a wall clock that creeps forward; sometimes right at the due
    // boundary of the last send, sometimes anywhere in the 64-bit range.
    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] thr;
        thr = TIME_W'(interval_in_force()) * 64'd1000;
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1, 2: return last_sent_ms + thr + $urandom_range(0, 2) - 1;
            default: begin
                wall_ms += $urandom_range(0, 40000);
                return wall_ms;
            end
        endcase
    endfunction

    function automatic logic [RTT_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return RTT_W'($urandom);
            1, 2, 3: return RTT_W'($urandom_range(0, 2000));
            default: return RTT_W'($urandom_range(0, 400));
        endcase
    endfunction

    // Offers one event request and waits for the handshake. With pacing on,
    // requests go out in bursts of random length separated by random gaps.
    task automatic post_event(
        input logic [KIND_W-1:0] kind,
        input logic [TIME_W-1:0] now,
        input logic [RTT_W-1:0]  sample
    );
        int gap;
        if (pace_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                repeat (gap) @(negedge i_clk) evt_bus.valid <= 1'b0;
            end
            burst_left--;
        end
        @(negedge i_clk);
        evt_bus.valid      <= 1'b1;
        evt_bus.kind       <= kind;
        evt_bus.now_ms     <= now;
        evt_bus.rtt_sample <= sample;
        do @(posedge i_clk); while (evt_bus.ready !== 1'b1);
        status_queue.push_back(apply_event(kind, now, sample));
        requests_sent++;
    endtask

    task automatic post_random(input logic [KIND_W-1:0] kind);
        post_event(kind, pick_time(), pick_sample());
    endtask

    // Stops offering requests and waits until every status is back, then
    // lets the pipeline settle.
    task automatic wait_for_results();
        @(negedge i_clk) evt_bus.valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_register(input t_reg_idx idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            REG_MIN_INTERVAL: cfg_min_sec = value;
            REG_MAX_INTERVAL: cfg_max_sec = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk) cfg_bus.valid <= 1'b0;
    endtask

    // Drives the smoothed RTT to exactly target using the sample that hits it
    // in one step; while that sample would be negative, zeros pull it down.
    task automatic steer_rtt(input int target);
        int need;
        do begin
            need = (rtt_avg == 0) ? target : 4 * target - 3 * int'(rtt_avg);
            if (need < 0)
                need = 0;
            post_event(K_RTT, wall_ms, RTT_W'(need));
        end while (int'(rtt_avg) != target);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset: 15 s minimum interval, no send yet recorded.
    task automatic test_reset_defaults();
        int k;
        post_event(K_QUERY, 64'd0, 16'd0);
        post_event(K_QUERY, 64'd14999, 16'hFFFF);
        post_event(K_QUERY, 64'd15000, 16'd0);
        post_event(K_CHECK, 64'd15000, 16'd0);     // no misses, must not fire
        for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            post_event(KIND_W'(k), {TIME_W{1'b1}}, 16'hFFFF);
    endtask

    // Smoothed RTT right on both sides of the 50 ms and 300 ms thresholds,
    // including a zero sample on a zero average and a full-scale sample.
    task automatic test_rtt_steering();
        wall_ms = 64'd20000;
        steer_rtt(0);
        steer_rtt(49);
        steer_rtt(50);
        steer_rtt(300);
        steer_rtt(301);
        post_event(K_RTT, wall_ms, 16'hFFFF);
    endtask

    // Miss counting, the dead flag and its clearing, due at its exact
    // boundary, and a send time near the top of the range that wraps.
    task automatic test_probe_liveness();
        logic [TIME_W-1:0] thr;
        wall_ms = 64'd1000;
        post_event(K_SENT, wall_ms, 16'd0);
        post_event(K_CHECK, wall_ms + 5, 16'd0);
        post_event(K_SENT, wall_ms + 10, 16'd0);
        post_event(K_SENT, wall_ms + 20, 16'd0);
        post_event(K_CHECK, wall_ms + 30, 16'd0);  // third miss: declares dead
        post_event(K_QUERY, {TIME_W{1'b1}}, 16'd0);
        post_event(K_SENT, wall_ms + 40, 16'd0);
        post_event(K_CHECK, wall_ms + 50, 16'd0);
        post_event(K_REPLY, wall_ms + 60, 16'd0);
        thr = TIME_W'(interval_in_force()) * 64'd1000;
        post_event(K_QUERY, last_sent_ms + thr - 1, 16'd0);
        post_event(K_QUERY, last_sent_ms + thr, 16'd0);
        post_event(K_SENT, 64'hFFFF_FFFF_FFFF_FC18, 16'd0);
        post_event(K_QUERY, 64'd0, 16'd0);         // only 1000 ms after, wrapped
        post_event(K_QUERY, last_sent_ms + thr, 16'd0);
        post_event(K_REPLY, 64'd0, 16'd0);
    endtask

    // Miss counter must stop at its cap and still clear on a reply.
    task automatic test_miss_saturation();
        repeat (int'(MISS_CAP) + 5)
            post_random(K_SENT);
        post_random(K_CHECK);
        post_random(K_QUERY);
        post_random(K_REPLY);
        post_random(K_CHECK);
    endtask

    // Interval registers at zero, one and full scale, min above max, and
    // each interval choice checked at its due boundary.
    task automatic test_interval_settings();
        logic [SEC_W-1:0]  mins[5] = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd300};
        logic [SEC_W-1:0]  maxs[5] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd7};
        int                targets[3] = '{400, 150, 20};
        logic [TIME_W-1:0] thr;
        for (int s = 0; s < 5; s++) begin
            wait_for_results();
            write_register(REG_MIN_INTERVAL, mins[s]);
            write_register(REG_MAX_INTERVAL, maxs[s]);
            post_random(K_SENT);
            for (int t = 0; t < 3; t++) begin
                steer_rtt(targets[t]);
                thr = TIME_W'(interval_in_force()) * 64'd1000;
                post_event(K_QUERY, last_sent_ms + thr - 1, 16'd0);
                post_event(K_QUERY, last_sent_ms + thr, 16'd0);
            end
            post_random(K_REPLY);
        end
    endtask

    // The receiver holds off while the sender keeps offering back to back,
    // so the block fills and has to drop its input ready.
    task automatic test_backpressure();
        wait_for_results();
        pace_sender   = 1'b0;
        hold_off_left = HOLD_OFF;
        repeat (30)
            post_random(KIND_W'($urandom_range(0, 4)));
        pace_sender = 1'b1;
        wait_for_results();
    endtask

    // One phase of random traffic, mostly well-formed probe exchanges and
    // outages, the rest RTT updates, bare queries and noise.
    task automatic run_traffic_phase(
        input logic [SEC_W-1:0] min_sec,
        input logic [SEC_W-1:0] max_sec,
        input int               budget
    );
        int stop_at;
        wait_for_results();
        write_register(REG_MIN_INTERVAL, min_sec);
        write_register(REG_MAX_INTERVAL, max_sec);
        wall_ms = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                              : TIME_W'($urandom_range(0, 1000000));
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    post_random(K_SENT);
                    repeat ($urandom_range(0, 3)) post_random(K_QUERY);
                    post_random(K_CHECK);
                    if ($urandom_range(0, 3) != 0)
                        post_random(K_REPLY);
                end
                3, 4: begin
                    repeat ($urandom_range(2, 6)) begin
                        post_random(K_SENT);
                        post_random(K_CHECK);
                    end
                    post_random(K_QUERY);
                    if ($urandom_range(0, 1) != 0)
                        post_random(K_REPLY);
                end
                5, 6: repeat ($urandom_range(1, 4)) post_random(K_RTT);
                7: repeat ($urandom_range(1, 3)) post_random(K_QUERY);
                8: post_random(KIND_W'($urandom_range(0, 7)));
                default: post_random(KIND_SPARE_FIRST + KIND_W'($urandom_range(0, 2)));
            endcase
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(16'd0, 16'd0, 150);
        run_traffic_phase(16'd1, 16'hFFFF, 150);
        run_traffic_phase(SEC_W'($urandom_range(1, 400)), SEC_W'($urandom_range(1, 400)), 150);
        run_traffic_phase(16'hFFFF, 16'd0, 150);
    endtask

    // ------------------------------------------------------------------
    // Receiver: switches between stall patterns on its own; a long hold-off
    // requested by a test is counted down here and takes priority.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_off_left--;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_STEADY:  res_bus.ready <= 1'b1;
                RX_COIN:    res_bus.ready <= 1'($urandom_range(0, 1));
                RX_CADENCE: res_bus.ready <= (rx_tick % 4 != 3);
                default:    res_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Status checker: every returned status against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_keepalive_status want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (status_queue.size() == 0) begin
                mismatch_count++;
                $error("status returned with no request outstanding");
            end else begin
                want = status_queue.pop_front();
                results_checked++;
                if (want.due)
                    due_seen++;
                if (want.check_fired)
                    fired_seen++;
                if (res_bus.due !== want.due) begin
                    mismatch_count++;
                    $error("due: expected %0b, got %0b", want.due, res_bus.due);
                end
                if (res_bus.dead !== want.dead) begin
                    mismatch_count++;
                    $error("dead: expected %0b, got %0b", want.dead, res_bus.dead);
                end
                if (res_bus.check_fired !== want.check_fired) begin
                    mismatch_count++;
                    $error("check_fired: expected %0b, got %0b",
                           want.check_fired, res_bus.check_fired);
                end
                if (res_bus.interval_sec !== want.interval_sec) begin
                    mismatch_count++;
                    $error("interval_sec: expected %0d, got %0d",
                           want.interval_sec, res_bus.interval_sec);
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d statuses outstanding",
                     quiet_cycles, status_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        evt_bus.valid      = 1'b0;
        evt_bus.kind       = K_QUERY;
        evt_bus.now_ms     = '0;
        evt_bus.rtt_sample = '0;
        res_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_MIN_INTERVAL;
        cfg_bus.data       = '0;

        // shadow state as after reset: zero registers mean the defaults
        cfg_min_sec  = '0;
        cfg_max_sec  = '0;
        rtt_avg      = '0;
        ivl_choice   = CH_MIN;
        last_sent_ms = '0;
        miss_count   = '0;
        link_dead    = 1'b0;

        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        cfg_writes      = 0;
        due_seen        = 0;
        fired_seen      = 0;
        quiet_cycles    = 0;
        wall_ms         = '0;
        pace_sender     = 1'b1;
        burst_left      = 0;
        hold_off_left   = 0;
        rx_mode         = RX_STEADY;
        rx_mode_left    = 0;
        rx_tick         = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rtt_steering();
        test_probe_liveness();
        test_miss_saturation();
        test_interval_settings();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        $display("Checked %0d keepalive statuses from %0d requests across %0d register writes.",
                 results_checked, requests_sent, cfg_writes);
        $display("Probes found due %0d times; liveness check declared the link dead %0d times.",
                 due_seen, fired_seen);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rak_pkg.sv
hw/rtl/rak_ifs.sv
hw/rtl/rak_cfg.sv
hw/rtl/rak_core.sv
hw/rtl/rtt_adaptive_keepalive.sv
test/rtt_adaptive_keepalive_test.sv
